// File: rtl/core/mm4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 integer matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM    = 4;
  localparam int IDX_W  = 2;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int DATA_W = 32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MUL  = 1'b1;
  localparam logic MAT_A    = 1'b0;
  localparam logic MAT_B    = 1'b1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  typedef struct packed {
    logic                     req_type;
    logic                     which_matrix;
    logic [IDX_W-1:0]         col_index;
    logic [IDX_W-1:0]         row_index;
    logic signed [DATA_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_col;
    logic [IDX_W-1:0]         out_row;
    logic signed [DATA_W-1:0] product_value;
    logic                     is_last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/int_matrix_multiply_4x4_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int_matrix_multiply_4x4_top
// Integer matrix product C = A * B over two stored DIM x DIM matrices.
//
// Items enter on the in_ channel (valid/ready). A load item writes one
// element of A or B; loads outside DIM are dropped. A multiply item
// produces DIM*DIM result items on the out_ channel in column order, each
// with its column, row and a last marker on the final one. Each product
// element issues DIM reads into the one shared multiply-accumulate unit,
// waits for its product and sum registers to drain, and then holds on the
// output until taken. in_ready is low for the whole multiply. When the
// receiver stalls, the result item holds on out_ and the sequencer waits.
// Reset clears the control state only; matrix elements hold no value
// until loaded.
// ----------------------------------------------------------------------------
module int_matrix_multiply_4x4_top import mm4_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic              load_ok;
  logic              wr_a;
  logic              wr_b;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [DATA_W-1:0] a_data;
  logic [DATA_W-1:0] b_data;
  logic [DATA_W-1:0] acc;
  logic              mac_busy;
  mac_ctrl_t         mac_ctrl;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  row;
  logic              last;

  assign load_ok = in_valid && in_ready && (in_item.req_type == REQ_LOAD)
                   && ({1'b0, in_item.col_index} < (IDX_W + 1)'(DIM))
                   && ({1'b0, in_item.row_index} < (IDX_W + 1)'(DIM));
  assign wr_a    = load_ok && (in_item.which_matrix == MAT_A);
  assign wr_b    = load_ok && (in_item.which_matrix == MAT_B);
  assign wr_addr = {in_item.col_index, in_item.row_index};

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (in_item.elem_value),
    .rd_addr (a_addr),
    .rd_data (a_data)
  );

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (in_item.elem_value),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  mm4_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_item.req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mac_busy  (mac_busy),
    .mac_ctrl  (mac_ctrl),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .col       (col),
    .row       (row),
    .last      (last)
  );

  mm4_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .a_data (a_data),
    .b_data (b_data),
    .busy   (mac_busy),
    .acc    (acc)
  );

  always_comb begin
    out_item.out_col       = col;
    out_item.out_row       = row;
    out_item.product_value = acc;
    out_item.is_last       = last;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result item is pending");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item.is_last |=> in_ready)
    else $error("block not idle after the last result item");

  a_next_recomputes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item.is_last |=> !out_valid && !in_ready)
    else $error("result item shown before its sum was computed");

  a_no_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !mac_busy)
    else $error("result item shown while the accumulator is still summing");

endmodule
`default_nettype wire

// File: rtl/core/mm4_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/core/mm4_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_mac
// Shared multiply-accumulate unit: registered product, then wrapping sum.
// ----------------------------------------------------------------------------
module mm4_mac import mm4_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mac_ctrl_t         ctrl,
  input  wire logic [DATA_W-1:0] a_data,
  input  wire logic [DATA_W-1:0] b_data,
  output logic                   busy,
  output logic      [DATA_W-1:0] acc
);

  logic              dv_r, dv_nxt;
  logic              pv_r, pv_nxt;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;

  always_comb begin
    dv_nxt   = ctrl.issue;
    pv_nxt   = dv_r;
    prod_nxt = dv_r ? a_data * b_data : prod_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + prod_r;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      dv_r <= dv_nxt;
      pv_r <= pv_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign busy = dv_r | pv_r;
  assign acc  = acc_r;

endmodule
`default_nettype wire

// File: rtl/core/mm4_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_seq
// Sequencer that walks the product elements and the inner index.
// ----------------------------------------------------------------------------
module mm4_seq import mm4_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              mac_busy,
  output mac_ctrl_t              mac_ctrl,
  output logic      [ADDR_W-1:0] a_addr,
  output logic      [ADDR_W-1:0] b_addr,
  output logic      [IDX_W-1:0]  col,
  output logic      [IDX_W-1:0]  row,
  output logic                   last
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             start;
  logic             emit_done;

  assign start     = (state_r == ST_IDLE) && in_valid && (in_req == REQ_MUL);
  assign emit_done = (state_r == ST_EMIT) && out_ready;
  assign last      = (c_r == IDX_LAST) && (r_r == IDX_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          state_nxt = last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    out_valid      = (state_r == ST_EMIT);
    mac_ctrl.issue = (state_r == ST_ISSUE);
    mac_ctrl.clear = (state_r == ST_ISSUE) && (k_r == '0);
  end

  always_comb begin
    c_nxt = c_r;
    r_nxt = r_r;
    k_nxt = k_r;
    if (start) begin
      c_nxt = '0;
      r_nxt = '0;
      k_nxt = '0;
    end else if (state_r == ST_ISSUE) begin
      k_nxt = (k_r == IDX_LAST) ? '0 : k_r + 1'b1;
    end else if (emit_done && !last) begin
      if (r_r == IDX_LAST) begin
        r_nxt = '0;
        c_nxt = c_r + 1'b1;
      end else begin
        r_nxt = r_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      c_r     <= '0;
      r_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      c_r     <= c_nxt;
      r_r     <= r_nxt;
      k_r     <= k_nxt;
    end
  end

  assign a_addr = {k_r, r_r};
  assign b_addr = {c_r, k_r};
  assign col    = c_r;
  assign row    = r_r;

endmodule
`default_nettype wire

// File: tb/mm4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_checker
// Watches both channels of the 4x4 integer matrix multiplier. Accepted load
// items update a private copy of A and B. Each accepted multiply item queues
// the sixteen elements of C = A * B in column order, wrapped to 32 bits.
// Every accepted result item is compared field by field with the oldest
// queued element. The failure count and the number of elements still due
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module mm4_checker import mm4_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        failures,
  output int        outstanding
);

  logic [DATA_W-1:0] mat_a [DEPTH];
  logic [DATA_W-1:0] mat_b [DEPTH];
  out_item_t         due_products [$];

  function automatic logic [DATA_W-1:0] product_at(int row, int col);
    logic [DATA_W-1:0] acc;
    int                k;
    acc = '0;
    for (k = 0; k < DIM; k++) begin
      acc = acc + mat_a[k * DIM + row] * mat_b[col * DIM + k];
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        c;
    int        r;
    if (!rst_n) begin
      failures    = 0;
      outstanding = 0;
      due_products.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_item.req_type == REQ_LOAD) begin
          if (in_item.col_index < DIM && in_item.row_index < DIM) begin
            if (in_item.which_matrix == MAT_A) begin
              mat_a[in_item.col_index * DIM + in_item.row_index] = in_item.elem_value;
            end else begin
              mat_b[in_item.col_index * DIM + in_item.row_index] = in_item.elem_value;
            end
          end
        end else begin
          for (c = 0; c < DIM; c++) begin
            for (r = 0; r < DIM; r++) begin
              want.out_col       = IDX_W'(c);
              want.out_row       = IDX_W'(r);
              want.product_value = product_at(r, c);
              want.is_last       = (c == DIM - 1) && (r == DIM - 1);
              due_products.push_back(want);
            end
          end
        end
      end
      if (out_valid && out_ready) begin
        if (due_products.size() == 0) begin
          if (failures < 10) begin
            $display("unexpected result: col %0d row %0d value %0d last %0b",
                     out_item.out_col, out_item.out_row, out_item.product_value,
                     out_item.is_last);
          end
          failures++;
        end else begin
          want = due_products.pop_front();
          if (out_item.out_col !== want.out_col || out_item.out_row !== want.out_row ||
              out_item.product_value !== want.product_value ||
              out_item.is_last !== want.is_last) begin
            if (failures < 10) begin
              $display("mismatch: expected col %0d row %0d value %0d last %0b",
                       want.out_col, want.out_row, want.product_value, want.is_last);
              $display("          actual   col %0d row %0d value %0d last %0b",
                       out_item.out_col, out_item.out_row, out_item.product_value,
                       out_item.is_last);
            end
            failures++;
          end
        end
      end
      outstanding = due_products.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the 4x4 integer matrix multiplier. Both matrices are first
// filled with extreme values, so no multiply ever reads an unloaded element.
// A few directed multiplies and loads follow, then random loads with a
// multiply mixed in at random. Both channels idle at random, except for one
// stretch in which neither idles, and the receiver holds off once for long
// enough that the block stalls its input. The checker predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module tb import mm4_pkg::*; ();

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 600;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int   failures;
  int   outstanding;
  int   cycles        = 0;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 20;
  int   results_taken = 0;
  int   hold_left     = 0;
  logic hold_done     = 1'b0;

  int_matrix_multiply_4x4_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  mm4_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .failures   (failures),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // The receiver stalls once for a long stretch after a few multiplies.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_taken >= 3 * DEPTH) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && out_valid && out_ready) begin
      results_taken <= results_taken + 1;
    end
  end

  function automatic in_item_t load_item(logic which, logic [IDX_W-1:0] col,
                                         logic [IDX_W-1:0] row, logic [DATA_W-1:0] value);
    in_item_t it;
    it.req_type     = REQ_LOAD;
    it.which_matrix = which;
    it.col_index    = col;
    it.row_index    = row;
    it.elem_value   = value;
    return it;
  endfunction

  function automatic in_item_t mul_item();
    in_item_t it;
    it.req_type     = REQ_MUL;
    it.which_matrix = 1'($urandom_range(1));
    it.col_index    = IDX_W'($urandom_range(3));
    it.row_index    = IDX_W'($urandom_range(3));
    it.elem_value   = $urandom;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(3))
      0: rand_value = $urandom_range(7) - 3;
      1: rand_value = {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom_range(3))};
      2: rand_value = $urandom_range(65535);
      default: rand_value = $urandom;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] extremes [6];
    in_item_t          it;
    int                m;
    int                c;
    int                r;
    int                i;
    extremes = '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0, 32'h1, 32'h80000001};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (m = 0; m < 2; m++) begin
      for (c = 0; c < DIM; c++) begin
        for (r = 0; r < DIM; r++) begin
          send_item(load_item(m == 0 ? MAT_A : MAT_B, IDX_W'(c), IDX_W'(r),
                              extremes[(m * DEPTH + c * DIM + r) % 6]));
        end
      end
    end
    it = '{req_type: REQ_MUL, which_matrix: MAT_B, col_index: IDX_LAST,
           row_index: IDX_LAST, elem_value: 32'hFFFFFFFF};
    send_item(it);
    it = '{req_type: REQ_MUL, which_matrix: MAT_A, col_index: '0,
           row_index: '0, elem_value: 32'h0};
    send_item(it);
    send_item(load_item(MAT_A, '0, '0, 32'h80000000));
    send_item(load_item(MAT_B, '0, '0, 32'h80000000));
    send_item(load_item(MAT_A, IDX_LAST, IDX_LAST, 32'h7FFFFFFF));
    send_item(load_item(MAT_B, IDX_LAST, IDX_LAST, 32'h7FFFFFFF));
    send_item(mul_item());

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (i == 300) begin
        send_idle_pct = 20;
        recv_idle_pct = 20;
      end
      if ($urandom_range(11) == 0) begin
        send_item(mul_item());
      end else begin
        send_item(load_item(1'($urandom_range(1)), IDX_W'($urandom_range(3)),
                            IDX_W'($urandom_range(3)), rand_value()));
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (2 * DIM * (DIM + 4)) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
